// ===== sv/blg_pkg.sv =====
// Shared types and constants of the battery level gauge.
// Used by every module of the block; depends on nothing.
package blg_pkg;

  localparam int TABLE_STEPS = 100;
  localparam int CELL_COUNT  = 4;

  localparam int IDX_W   = $clog2(TABLE_STEPS);
  localparam int CNT_W   = $clog2(TABLE_STEPS + 1);
  localparam int LVL_W   = 7;
  localparam int LEVEL_MAX = 127;
  localparam int SUM_W   = $clog2(CELL_COUNT * LEVEL_MAX + 1);

  localparam int MV_W      = 16;
  localparam int CELL_MV_W = 14;
  localparam int ADC_W     = 11;
  localparam int PROD_W    = ADC_W + MV_W;
  localparam int ADC_SCALE_SH = 10;
  localparam int CELL_MV_MAX  = 9999;

  localparam int DVD_W  = 22;
  localparam int STEP_W = $clog2(DVD_W + 1);
  localparam logic [DVD_W-1:0] REF_NUMERATOR = DVD_W'(2097152);
  localparam logic [MV_W-1:0] SUPPLY_MAX = '1;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_REF  = 2'd1,
    CMD_BATT = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [ADC_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [CELL_MV_W-1:0] mv;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [MV_W-1:0]      wr_data;
  } srch_req_t;

  typedef struct packed {
    logic             done;
    logic [LVL_W-1:0] level;
  } srch_rsp_t;

endpackage

// ===== sv/blg_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on blg_pkg for widths and request/response types.
module blg_divider
  import blg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [ADC_W-1:0]  dsr_r;
  logic [ADC_W-1:0]  rem_r;
  logic [DVD_W-1:0]  q_r;
  logic [ADC_W:0]    trial;
  logic              ge;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? ADC_W'(trial - {1'b0, dsr_r}) : trial[ADC_W-1:0];
      q_r   <= {q_r[DVD_W-2:0], ge};
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

// ===== sv/blg_search.sv =====
// Threshold table memory and the linear walk that finds a charge level.
// Depends on blg_pkg for widths and request/response types.
module blg_search
  import blg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  srch_req_t req,
  output srch_rsp_t rsp
);

  logic [MV_W-1:0]      mem [TABLE_STEPS];
  logic [MV_W-1:0]      rdata_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 chk_vld_r;
  logic [CNT_W-1:0]     issue_r;
  logic [IDX_W-1:0]     chk_r;
  logic [CELL_MV_W-1:0] mv_r;
  logic [LVL_W-1:0]     level_r;
  logic                 hit;
  logic                 last;
  logic                 rd_en;
  logic [CNT_W-1:0]     lvl_full;

  assign hit      = chk_vld_r && (rdata_r <= MV_W'(mv_r));
  assign last     = chk_vld_r && (32'(chk_r) == TABLE_STEPS - 1);
  assign rd_en    = busy_r && !hit && !last && (32'(issue_r) < TABLE_STEPS);
  assign lvl_full = CNT_W'(TABLE_STEPS) - CNT_W'(chk_r);

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[issue_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      chk_vld_r <= 1'b0;
      issue_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r    <= 1'b1;
        chk_vld_r <= 1'b0;
        issue_r   <= '0;
      end else if (busy_r) begin
        if (hit || last) begin
          busy_r    <= 1'b0;
          done_r    <= 1'b1;
          chk_vld_r <= 1'b0;
        end else begin
          chk_vld_r <= rd_en;
          if (rd_en) begin
            issue_r <= issue_r + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mv_r <= req.mv;
    end
    if (rd_en) begin
      chk_r <= issue_r[IDX_W-1:0];
    end
    if (busy_r && hit) begin
      level_r <= (32'(lvl_full) > LEVEL_MAX) ? LVL_W'(LEVEL_MAX) : LVL_W'(lvl_full);
    end else if (busy_r && last) begin
      level_r <= '0;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.level = level_r;

endmodule

// ===== sv/battery_level_gauge_unit.sv =====
// Battery level gauge top level: command sequencer, cell level store, result register.
// Depends on blg_pkg, blg_divider and blg_search.
//
// Usage: one command per input transfer (in_valid/in_stall). A load command writes one
// entry of the descending threshold table, if its index is below 100; a reference
// command sets the supply estimate to 2097152/adc_sample (saturated, div_error on
// zero); a battery command scales the sample by the supply, walks the table for the
// level, stores it for the channel and reports the mean of all cell levels. Every
// command yields one result transfer (out_valid/out_stall).
// A reference command waits on the one-bit-per-cycle divider; a battery command
// waits on the table walk through the single read port of the table memory.
// One command is in work at a time; the next is taken once the result sits in the
// output register, even while the receiver stalls it. A stalled result holds; a
// finished command waits for the output register to free.
// Reset clears the supply estimate, cell levels, mean and output valid; the table
// contents stay undefined until loaded.
module battery_level_gauge_unit
  import blg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic [1:0]           in_channel,
  input  logic [6:0]           in_entry_index,
  input  logic [MV_W-1:0]      in_entry_value,
  input  logic [ADC_W-1:0]     in_adc_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [MV_W-1:0]      out_supply_mv,
  output logic [CELL_MV_W-1:0] out_cell_mv,
  output logic [LVL_W-1:0]     out_cell_level,
  output logic [LVL_W-1:0]     out_mean_level,
  output logic                 out_div_error
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_SAT  = 7'b0001000,
    ST_SRCH = 7'b0010000,
    ST_SUM  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           chan_r;
  logic [ADC_W-1:0]     adc_r;
  logic [MV_W-1:0]      supply_r;
  logic [PROD_W-1:0]    prod_r;
  logic [CELL_MV_W-1:0] cell_mv_r;
  logic [LVL_W-1:0]     cell_level_r;
  logic [LVL_W-1:0]     mean_r;
  logic                 err_r;
  logic [LVL_W-1:0]     levels_r [CELL_COUNT];

  logic                 out_valid_r;
  logic [MV_W-1:0]      out_supply_r;
  logic [CELL_MV_W-1:0] out_cell_mv_r;
  logic [LVL_W-1:0]     out_cell_level_r;
  logic [LVL_W-1:0]     out_mean_r;
  logic                 out_err_r;

  logic                 in_xfer;
  logic                 out_load;
  logic [PROD_W-ADC_SCALE_SH-1:0] scaled;
  logic [CELL_MV_W-1:0] cell_mv_sat;
  logic [SUM_W-1:0]     level_sum;
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  srch_req_t            srch_req;
  srch_rsp_t            srch_rsp;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign scaled      = prod_r[PROD_W-1:ADC_SCALE_SH];
  assign cell_mv_sat = (32'(scaled) > CELL_MV_MAX) ? CELL_MV_W'(CELL_MV_MAX)
                                                   : CELL_MV_W'(scaled);

  always_comb begin
    level_sum = '0;
    for (int k = 0; k < CELL_COUNT; k++) begin
      level_sum = level_sum + SUM_W'(levels_r[k]);
    end
  end

  always_comb begin
    div_req = '0;
    if (in_xfer && cmd_t'(in_cmd) == CMD_REF && in_adc_sample != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = REF_NUMERATOR;
      div_req.divisor  = in_adc_sample;
      div_req.steps    = STEP_W'(DVD_W);
    end
  end

  always_comb begin
    srch_req         = '0;
    srch_req.wr_en   = in_xfer && cmd_t'(in_cmd) == CMD_LOAD
                       && (32'(in_entry_index) < TABLE_STEPS);
    srch_req.wr_addr = in_entry_index[IDX_W-1:0];
    srch_req.wr_data = in_entry_value;
    srch_req.start   = (state_r == ST_SAT);
    srch_req.mv      = cell_mv_sat;
  end

  blg_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  blg_search u_srch (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (srch_req),
    .rsp   (srch_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (cmd_t'(in_cmd))
            CMD_REF:  state_nxt = (in_adc_sample == '0) ? ST_DONE : ST_DIV;
            CMD_BATT: state_nxt = ST_MUL;
            CMD_LOAD,
            CMD_NOP:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DIV:  if (div_rsp.done) state_nxt = ST_DONE;
      ST_MUL:  state_nxt = ST_SAT;
      ST_SAT:  state_nxt = ST_SRCH;
      ST_SRCH: if (srch_rsp.done) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      supply_r     <= '0;
      mean_r       <= '0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < CELL_COUNT; k++) begin
        levels_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SUM) begin
        mean_r <= LVL_W'(level_sum / SUM_W'(CELL_COUNT));
      end
      if (state_r == ST_DIV && div_rsp.done) begin
        supply_r <= (div_rsp.quot[DVD_W-1:MV_W] != '0) ? SUPPLY_MAX
                                                       : div_rsp.quot[MV_W-1:0];
      end
      if (state_r == ST_SRCH && srch_rsp.done) begin
        for (int k = 0; k < CELL_COUNT; k++) begin
          if (32'(chan_r) == k) begin
            levels_r[k] <= srch_rsp.level;
          end
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      chan_r       <= in_channel;
      adc_r        <= in_adc_sample;
      cell_mv_r    <= '0;
      cell_level_r <= '0;
      err_r        <= (cmd_t'(in_cmd) == CMD_REF) && (in_adc_sample == '0);
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(adc_r) * PROD_W'(supply_r);
    end
    if (state_r == ST_SAT) begin
      cell_mv_r <= cell_mv_sat;
    end
    if (state_r == ST_SRCH && srch_rsp.done) begin
      cell_level_r <= srch_rsp.level;
    end
    if (out_load) begin
      out_supply_r     <= supply_r;
      out_cell_mv_r    <= cell_mv_r;
      out_cell_level_r <= cell_level_r;
      out_mean_r       <= mean_r;
      out_err_r        <= err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_supply_mv  = out_supply_r;
  assign out_cell_mv    = out_cell_mv_r;
  assign out_cell_level = out_cell_level_r;
  assign out_mean_level = out_mean_r;
  assign out_div_error  = out_err_r;

`ifndef ASSERT_OFF
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider finished outside a divide phase");

  a_srch_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    srch_rsp.done |-> (state_r == ST_SRCH))
    else $error("table walk finished outside the search phase");

  a_zero_ref: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_cmd == CMD_REF && in_adc_sample == '0)
      |=> (err_r && $stable(supply_r) && state_r == ST_DONE))
    else $error("zero reference reading did not flag an error");

  a_mv_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> (32'(cell_mv_r) <= CELL_MV_MAX))
    else $error("cell voltage above saturation limit");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for battery_level_gauge_unit: table loads, reference and battery readings.
// A directed table runs first, then random traffic checked against an in-bench gauge predictor.
// Depends on blg_pkg and the battery_level_gauge_unit RTL.
`timescale 1ns / 100ps

module testbench;
  import blg_pkg::*;

  localparam int unsigned REF_MV_NUM   = 2097152;
  localparam int unsigned ADC_DIV      = 1024;
  localparam int unsigned CELL_MV_CAP  = 9999;
  localparam int unsigned SUPPLY_CAP   = 65535;
  localparam int unsigned LVL_CAP      = 127;
  localparam int          RANDOM_ITEMS = 600;
  localparam int          DRAIN_CYCLES = 150;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          N_DIRECTED   = 20;

  typedef struct packed {
    cmd_t             cmd;
    logic [1:0]       channel;
    logic [6:0]       entry_index;
    logic [MV_W-1:0]  entry_value;
    logic [ADC_W-1:0] adc_sample;
  } reading_t;

  typedef struct packed {
    logic [MV_W-1:0]      supply_mv;
    logic [CELL_MV_W-1:0] cell_mv;
    logic [LVL_W-1:0]     cell_level;
    logic [LVL_W-1:0]     mean_level;
    logic                 div_error;
  } gauge_result_t;

  typedef struct packed {
    reading_t      rd;
    logic          typed;
    gauge_result_t want;
  } directed_row_t;

  typedef enum int {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_LIGHT
  } stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_cmd = 2'd0;
  logic [1:0]           in_channel = 2'd0;
  logic [6:0]           in_entry_index = 7'd0;
  logic [MV_W-1:0]      in_entry_value = '0;
  logic [ADC_W-1:0]     in_adc_sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [MV_W-1:0]      out_supply_mv;
  logic [CELL_MV_W-1:0] out_cell_mv;
  logic [LVL_W-1:0]     out_cell_level;
  logic [LVL_W-1:0]     out_mean_level;
  logic                 out_div_error;

  logic [MV_W-1:0]  supply_est = '0;
  logic [MV_W-1:0]  thresholds [TABLE_STEPS];
  bit               entry_loaded [TABLE_STEPS];
  logic [LVL_W-1:0] cell_lvls [CELL_COUNT];

  gauge_result_t expected_readings [$];
  gauge_result_t oldest_reading;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            burst_left = 0;
  stall_mode_t   stall_mode = STALL_NONE;
  int            stall_run = 0;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{'{CMD_NOP,  2'd0, 7'd0,   16'h0000, 11'd0},    1'b1, '{16'd0,     14'd0, 7'd0, 7'd0, 1'b0}},
    '{'{CMD_NOP,  2'd3, 7'd127, 16'hFFFF, 11'h7FF},  1'b1, '{16'd0,     14'd0, 7'd0, 7'd0, 1'b0}},
    '{'{CMD_REF,  2'd0, 7'd0,   16'h0000, 11'd0},    1'b1, '{16'd0,     14'd0, 7'd0, 7'd0, 1'b1}},
    '{'{CMD_REF,  2'd0, 7'd0,   16'h0000, 11'd1},    1'b1, '{16'd65535, 14'd0, 7'd0, 7'd0, 1'b0}},
    '{'{CMD_REF,  2'd0, 7'd0,   16'h0000, 11'd2047}, 1'b1, '{16'd1024,  14'd0, 7'd0, 7'd0, 1'b0}},
    '{'{CMD_LOAD, 2'd0, 7'd127, 16'h0000, 11'd0},    1'b1, '{16'd1024,  14'd0, 7'd0, 7'd0, 1'b0}},
    '{'{CMD_LOAD, 2'd0, 7'd100, 16'd1234, 11'd0},    1'b1, '{16'd1024,  14'd0, 7'd0, 7'd0, 1'b0}},
    '{'{CMD_LOAD, 2'd0, 7'd0,   16'hFFFF, 11'd0},    1'b1, '{16'd1024,  14'd0, 7'd0, 7'd0, 1'b0}},
    '{'{CMD_LOAD, 2'd0, 7'd99,  16'h0000, 11'd0},    1'b1, '{16'd1024,  14'd0, 7'd0, 7'd0, 1'b0}},
    '{'{CMD_LOAD, 2'd0, 7'd0,   16'd9999, 11'd0},    1'b1, '{16'd1024,  14'd0, 7'd0, 7'd0, 1'b0}},
    '{'{CMD_LOAD, 2'd0, 7'd1,   16'h0000, 11'd0},    1'b1, '{16'd1024,  14'd0, 7'd0, 7'd0, 1'b0}},
    '{'{CMD_BATT, 2'd0, 7'd0,   16'h0000, 11'd2047}, 1'b0, '0},
    '{'{CMD_BATT, 2'd1, 7'd0,   16'h0000, 11'd0},    1'b0, '0},
    '{'{CMD_REF,  2'd0, 7'd0,   16'h0000, 11'd32},   1'b0, '0},
    '{'{CMD_REF,  2'd0, 7'd0,   16'h0000, 11'd33},   1'b0, '0},
    '{'{CMD_BATT, 2'd3, 7'd0,   16'h0000, 11'd2047}, 1'b0, '0},
    '{'{CMD_BATT, 2'd2, 7'd0,   16'h0000, 11'd1},    1'b0, '0},
    '{'{CMD_REF,  2'd0, 7'd0,   16'h0000, 11'd0},    1'b0, '0},
    '{'{CMD_BATT, 2'd0, 7'd0,   16'h0000, 11'd1024}, 1'b0, '0},
    '{'{CMD_LOAD, 2'd0, 7'd2,   16'h8000, 11'd0},    1'b0, '0}
  };

  battery_level_gauge_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_channel     (in_channel),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_adc_sample  (in_adc_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_supply_mv  (out_supply_mv),
    .out_cell_mv    (out_cell_mv),
    .out_cell_level (out_cell_level),
    .out_mean_level (out_mean_level),
    .out_div_error  (out_div_error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [CELL_MV_W-1:0] cell_voltage(logic [ADC_W-1:0] adc);
    int unsigned mv;
    mv = (32'(adc) * 32'(supply_est)) / ADC_DIV;
    return (mv > CELL_MV_CAP) ? CELL_MV_W'(CELL_MV_CAP) : CELL_MV_W'(mv);
  endfunction

  function automatic logic [LVL_W-1:0] level_for(logic [CELL_MV_W-1:0] mv);
    for (int i = 0; i < TABLE_STEPS; i++) begin
      if (thresholds[i] <= 16'(mv)) begin
        return (TABLE_STEPS - i > LVL_CAP) ? LVL_W'(LVL_CAP) : LVL_W'(TABLE_STEPS - i);
      end
    end
    return '0;
  endfunction

  function automatic bit walk_ends_on_loaded(logic [ADC_W-1:0] adc);
    logic [CELL_MV_W-1:0] mv;
    mv = cell_voltage(adc);
    for (int i = 0; i < TABLE_STEPS; i++) begin
      if (!entry_loaded[i]) return 1'b0;
      if (thresholds[i] <= 16'(mv)) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic gauge_result_t gauge_predict(reading_t rd);
    gauge_result_t res;
    int unsigned   quo;
    int unsigned   lvl_sum;
    res = '0;
    case (rd.cmd)
      CMD_LOAD: begin
        if (rd.entry_index < TABLE_STEPS) begin
          thresholds[rd.entry_index] = rd.entry_value;
          entry_loaded[rd.entry_index] = 1'b1;
        end
      end
      CMD_REF: begin
        if (rd.adc_sample == '0) begin
          res.div_error = 1'b1;
        end else begin
          quo = REF_MV_NUM / 32'(rd.adc_sample);
          supply_est = (quo > SUPPLY_CAP) ? MV_W'(SUPPLY_CAP) : MV_W'(quo);
        end
      end
      CMD_BATT: begin
        res.cell_mv = cell_voltage(rd.adc_sample);
        res.cell_level = level_for(res.cell_mv);
        if (rd.channel < CELL_COUNT) cell_lvls[rd.channel] = res.cell_level;
      end
      default: ;
    endcase
    lvl_sum = 0;
    for (int k = 0; k < CELL_COUNT; k++) lvl_sum += cell_lvls[k];
    res.supply_mv = supply_est;
    res.mean_level = LVL_W'(lvl_sum / CELL_COUNT);
    return res;
  endfunction

  function automatic logic [MV_W-1:0] descending_value(int idx);
    return MV_W'((TABLE_STEPS - 1 - idx) * 100 + $urandom_range(1, 99));
  endfunction

  function automatic reading_t noise_reading();
    reading_t rd;
    rd.cmd = CMD_NOP;
    rd.channel = 2'($urandom_range(0, 3));
    rd.entry_index = 7'($urandom_range(0, 127));
    rd.entry_value = MV_W'($urandom_range(0, 65535));
    rd.adc_sample = ADC_W'($urandom_range(0, 2047));
    return rd;
  endfunction

  task automatic send_reading(reading_t rd, logic typed, gauge_result_t want);
    gauge_result_t res;
    int unsigned   gap;
    in_cmd <= rd.cmd;
    in_channel <= rd.channel;
    in_entry_index <= rd.entry_index;
    in_entry_value <= rd.entry_value;
    in_adc_sample <= rd.adc_sample;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    res = gauge_predict(rd);
    expected_readings.push_back(typed ? want : res);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 130) : $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_run = $urandom_range(8, 150);
    end else begin
      stall_run--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
      default:     out_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $error("result transfer with no reading pending");
        mismatch_count++;
      end else begin
        oldest_reading = expected_readings.pop_front();
        if (out_supply_mv !== oldest_reading.supply_mv) begin
          $error("supply_mv: expected %0d, got %0d", oldest_reading.supply_mv, out_supply_mv);
          mismatch_count++;
        end
        if (out_cell_mv !== oldest_reading.cell_mv) begin
          $error("cell_mv: expected %0d, got %0d", oldest_reading.cell_mv, out_cell_mv);
          mismatch_count++;
        end
        if (out_cell_level !== oldest_reading.cell_level) begin
          $error("cell_level: expected %0d, got %0d", oldest_reading.cell_level,
                 out_cell_level);
          mismatch_count++;
        end
        if (out_mean_level !== oldest_reading.mean_level) begin
          $error("mean_level: expected %0d, got %0d", oldest_reading.mean_level,
                 out_mean_level);
          mismatch_count++;
        end
        if (out_div_error !== oldest_reading.div_error) begin
          $error("div_error: expected %0d, got %0d", oldest_reading.div_error, out_div_error);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** battery_level_gauge_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    reading_t rd;
    int       fill_order [TABLE_STEPS];
    int       fill_pos;
    int       j;
    int       tmp;
    int       roll;
    for (int i = 0; i < TABLE_STEPS; i++) begin
      thresholds[i] = '0;
      entry_loaded[i] = 1'b0;
      fill_order[i] = i;
    end
    for (int k = 0; k < CELL_COUNT; k++) cell_lvls[k] = '0;
    for (int i = TABLE_STEPS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = fill_order[i];
      fill_order[i] = fill_order[j];
      fill_order[j] = tmp;
    end
    fill_pos = 0;
    burst_left = $urandom_range(0, 20);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      send_reading(directed_rows[r].rd, directed_rows[r].typed, directed_rows[r].want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      rd = noise_reading();
      roll = $urandom_range(0, 99);
      if (fill_pos < TABLE_STEPS && roll < 60) begin
        rd.cmd = CMD_LOAD;
        rd.entry_index = 7'(fill_order[fill_pos]);
        rd.entry_value = descending_value(fill_order[fill_pos]);
        fill_pos++;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          rd.cmd = CMD_BATT;
          case ($urandom_range(0, 9))
            0: rd.adc_sample = '0;
            1: rd.adc_sample = '1;
            2, 3: rd.adc_sample = ADC_W'($urandom_range(0, 60));
            default: ;
          endcase
        end else if (roll < 60) begin
          rd.cmd = CMD_REF;
          case ($urandom_range(0, 19))
            0: rd.adc_sample = '0;
            1, 2, 3: rd.adc_sample = ADC_W'($urandom_range(1, 64));
            default: rd.adc_sample = ADC_W'($urandom_range(300, 2047));
          endcase
        end else if (roll < 92) begin
          rd.cmd = CMD_LOAD;
          case ($urandom_range(0, 6))
            0: rd.entry_index = 7'($urandom_range(TABLE_STEPS, 127));
            1: rd.entry_index = 7'($urandom_range(0, TABLE_STEPS - 1));
            default: begin
              rd.entry_index = 7'($urandom_range(0, TABLE_STEPS - 1));
              rd.entry_value = descending_value(rd.entry_index);
            end
          endcase
        end
      end
      if (rd.cmd == CMD_BATT && !walk_ends_on_loaded(rd.adc_sample)) begin
        rd.cmd = CMD_LOAD;
        rd.entry_index = 7'(fill_order[fill_pos]);
        rd.entry_value = descending_value(fill_order[fill_pos]);
        fill_pos++;
      end
      send_reading(rd, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** battery_level_gauge_unit: PASSED **");
    end else begin
      $display("** battery_level_gauge_unit: FAILED **");
    end
    $finish;
  end

endmodule
